// ----- src/krm_pkg.sv -----
// Shared types and constants for the key request matcher.
package krm_pkg;

  localparam int unsigned DefDepth = 128;

  localparam int unsigned KeyW = 16;
  localparam int unsigned RidW = 7;
  localparam int unsigned DataW = 24;

  localparam logic CmdKey = 1'b0;
  localparam logic CmdReq = 1'b1;

  typedef struct packed {
    logic accept;
    logic load_out;
  } krm_ctrl_t;

  typedef struct packed {
    logic out_valid;
  } krm_stat_t;

endpackage

// ----- src/key_request_matcher_core.sv -----
// Top level of the key request matcher.
// Pairs key presses with waiting key requests through two rings of DEPTH-1
// entries each. Each word is handled in an accept cycle and a load state:
// the accept cycle updates the ring pointers and writes or reads one memory
// entry, and the load state loads the registered result into the output
// register. s_axis_tready is low from each accept until its result is loaded,
// so a new word is not taken before the last one is loaded; a result waiting
// at the output holds the word in the load state until it is taken. Each input
// word yields exactly one output word. A push into a full ring is discarded and flagged in m_axis_tuser.
module key_request_matcher_core
  import krm_pkg::*;
#(
  parameter int unsigned DEPTH = DefDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [DataW-1:0] s_axis_tdata,  // [15:0] key_code, [22:16] requester_id, [23] zero
  input  logic             s_axis_tuser,  // [0] command
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [DataW-1:0] m_axis_tdata,  // [15:0] deliver_key, [22:16] deliver_to, [23] zero
  output logic [1:0]       m_axis_tuser   // [0] delivered, [1] dropped
);

  krm_ctrl_t       ctrl;
  krm_stat_t       stat;
  logic            delivered, dropped;
  logic [KeyW-1:0] deliver_key;
  logic [RidW-1:0] deliver_to;

  krm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  krm_datapath #(
    .DEPTH(DEPTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .stat_o        (stat),
    .cmd_i         (s_axis_tuser),
    .key_i         (s_axis_tdata[KeyW-1:0]),
    .rid_i         (s_axis_tdata[KeyW+RidW-1:KeyW]),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .delivered_o   (delivered),
    .deliver_key_o (deliver_key),
    .deliver_to_o  (deliver_to),
    .dropped_o     (dropped)
  );

  assign m_axis_tdata = {1'b0, deliver_to, deliver_key};
  assign m_axis_tuser = {dropped, delivered};

endmodule

// ----- src/krm_ctrl.sv -----
// Controller state machine: sequences accept and result load.
module krm_ctrl
  import krm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  logic      out_ready_i,
  input  krm_stat_t stat_i,
  output krm_ctrl_t ctrl_o
);

  localparam logic StIdle = 1'b0;
  localparam logic StLoad = 1'b1;

  logic state_q, state_d;

  assign in_ready_o      = (state_q == StIdle);
  assign ctrl_o.accept   = in_ready_o && in_valid_i;
  assign ctrl_o.load_out = (state_q == StLoad) && (!stat_i.out_valid || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (ctrl_o.accept) state_d = StLoad;
      StLoad: if (ctrl_o.load_out) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- src/krm_datapath.sv -----
// Datapath: ring pointers, key and requester memories, output register.
module krm_datapath
  import krm_pkg::*;
#(
  parameter int unsigned DEPTH = DefDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  krm_ctrl_t       ctrl_i,
  output krm_stat_t       stat_o,
  input  logic            cmd_i,
  input  logic [KeyW-1:0] key_i,
  input  logic [RidW-1:0] rid_i,
  input  logic            out_ready_i,
  output logic            out_valid_o,
  output logic            delivered_o,
  output logic [KeyW-1:0] deliver_key_o,
  output logic [RidW-1:0] deliver_to_o,
  output logic            dropped_o
);

  localparam int unsigned PW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam logic [PW-1:0] PLast = PW'(DEPTH - 1);

  logic [KeyW-1:0] key_mem [DEPTH];
  logic [RidW-1:0] rid_mem [DEPTH];

  logic [PW-1:0] key_head_q, key_tail_q, req_head_q, req_tail_q;
  logic [PW-1:0] key_head_nx, key_tail_nx, req_head_nx, req_tail_nx;
  logic key_nonempty, req_nonempty, key_full, req_full;
  logic pop_key, pop_req, push_key, push_req, drop;

  logic            cmd_q, dlv_q, drop_q;
  logic [KeyW-1:0] key_q, key_rd_q;
  logic [RidW-1:0] rid_q, rid_rd_q;

  logic            out_valid_q;
  logic            dlv_out_q, drop_out_q;
  logic [KeyW-1:0] okey_q;
  logic [RidW-1:0] oto_q;

  function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
    nxt = (p == PLast) ? '0 : p + 1'b1;
  endfunction

  assign key_head_nx  = nxt(key_head_q);
  assign key_tail_nx  = nxt(key_tail_q);
  assign req_head_nx  = nxt(req_head_q);
  assign req_tail_nx  = nxt(req_tail_q);
  assign key_nonempty = (key_head_q != key_tail_q);
  assign req_nonempty = (req_head_q != req_tail_q);
  assign key_full     = (key_tail_nx == key_head_q);
  assign req_full     = (req_tail_nx == req_head_q);

  assign pop_req  = ctrl_i.accept && (cmd_i == CmdKey) && req_nonempty;
  assign push_key = ctrl_i.accept && (cmd_i == CmdKey) && !req_nonempty && !key_full;
  assign pop_key  = ctrl_i.accept && (cmd_i == CmdReq) && key_nonempty;
  assign push_req = ctrl_i.accept && (cmd_i == CmdReq) && !key_nonempty && !req_full;
  assign drop     = (cmd_i == CmdKey) ? (!req_nonempty && key_full)
                                      : (!key_nonempty && req_full);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_head_q <= '0;
      key_tail_q <= '0;
      req_head_q <= '0;
      req_tail_q <= '0;
    end else begin
      if (pop_key)  key_head_q <= key_head_nx;
      if (push_key) key_tail_q <= key_tail_nx;
      if (pop_req)  req_head_q <= req_head_nx;
      if (push_req) req_tail_q <= req_tail_nx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_key) key_mem[key_tail_q] <= key_i;
    if (pop_key)  key_rd_q <= key_mem[key_head_q];
  end

  always_ff @(posedge clk_i) begin
    if (push_req) rid_mem[req_tail_q] <= rid_i;
    if (pop_req)  rid_rd_q <= rid_mem[req_head_q];
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      cmd_q  <= cmd_i;
      key_q  <= key_i;
      rid_q  <= rid_i;
      dlv_q  <= pop_key || pop_req;
      drop_q <= drop;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_out) begin
      dlv_out_q  <= dlv_q;
      drop_out_q <= drop_q;
      okey_q     <= !dlv_q ? '0 : ((cmd_q == CmdKey) ? key_q : key_rd_q);
      oto_q      <= !dlv_q ? '0 : ((cmd_q == CmdKey) ? rid_rd_q : rid_q);
    end
  end

  assign stat_o.out_valid = out_valid_q;
  assign out_valid_o      = out_valid_q;
  assign delivered_o      = dlv_out_q;
  assign deliver_key_o    = okey_q;
  assign deliver_to_o     = oto_q;
  assign dropped_o        = drop_out_q;

endmodule

// ----- src/krm_checker.sv -----
// Port-level assertions for the key request matcher, bound to the top level.
module krm_checker
  import krm_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [DataW-1:0] m_axis_tdata,
  input logic [1:0]       m_axis_tuser
);

  logic s_acc;
  assign s_acc = s_axis_tvalid && s_axis_tready;

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_axis_tready)
    else $error("input accepted in back-to-back cycles");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && !m_axis_tvalid) |=> ##1 m_axis_tvalid)
    else $error("result missing two cycles after accept");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("word both delivered and dropped");

  a_quiet_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == '0))
    else $error("nonzero data on undelivered word");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("stalled output word changed");

endmodule

bind key_request_matcher_core krm_checker u_krm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// ----- tb/testbench.sv -----
// Testbench for key_request_matcher_core: directed and random stream traffic checked against a ring predictor.
`timescale 1ns / 1ps

module testbench;
  import krm_pkg::*;

  localparam int unsigned Depth = DefDepth;
  localparam int unsigned StallLimit = 5000;

  typedef struct {
    logic             delivered;
    logic [KeyW-1:0]  key;
    logic [RidW-1:0]  to;
    logic             dropped;
  } delivery_t;

  class delivery_board;
    logic [KeyW-1:0] key_ring[Depth];
    logic [RidW-1:0] req_ring[Depth];
    int unsigned     key_rd, key_wr, req_rd, req_wr;
    delivery_t       deliveries_due[$];
    int              errors;

    function new();
      key_rd = 0;
      key_wr = 0;
      req_rd = 0;
      req_wr = 0;
      errors = 0;
    endfunction

    function int unsigned step_ptr(int unsigned p);
      return (p + 1) % Depth;
    endfunction

    function int unsigned keys_queued();
      return (key_wr + Depth - key_rd) % Depth;
    endfunction

    function int unsigned reqs_queued();
      return (req_wr + Depth - req_rd) % Depth;
    endfunction

    function int unsigned pending();
      return deliveries_due.size();
    endfunction

    // predict the result of one accepted word
    function void note_event(logic cmd, logic [KeyW-1:0] key, logic [RidW-1:0] rid);
      delivery_t d;
      d = '{delivered: 1'b0, key: '0, to: '0, dropped: 1'b0};
      if (cmd == CmdKey) begin
        if (req_rd != req_wr) begin
          d.delivered = 1'b1;
          d.key = key;
          d.to = req_ring[req_rd];
          req_rd = step_ptr(req_rd);
        end else if (step_ptr(key_wr) == key_rd) begin
          d.dropped = 1'b1;
        end else begin
          key_ring[key_wr] = key;
          key_wr = step_ptr(key_wr);
        end
      end else begin
        if (key_rd != key_wr) begin
          d.delivered = 1'b1;
          d.key = key_ring[key_rd];
          d.to = rid;
          key_rd = step_ptr(key_rd);
        end else if (step_ptr(req_wr) == req_rd) begin
          d.dropped = 1'b1;
        end else begin
          req_ring[req_wr] = rid;
          req_wr = step_ptr(req_wr);
        end
      end
      deliveries_due.push_back(d);
    endfunction

    task report_mismatch(string what, int got, int want);
      errors++;
      $display("mismatch at %0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
    endtask

    task check_delivery(logic [DataW-1:0] data, logic [1:0] user);
      delivery_t d;
      if (deliveries_due.size() == 0) begin
        report_mismatch("word with nothing pending", data, 0);
      end else begin
        d = deliveries_due.pop_front();
        if (user[0] !== d.delivered) report_mismatch("delivered", user[0], d.delivered);
        if (user[1] !== d.dropped) report_mismatch("dropped", user[1], d.dropped);
        if (data[15:0] !== d.key) report_mismatch("deliver_key", data[15:0], d.key);
        if (data[22:16] !== d.to) report_mismatch("deliver_to", data[22:16], d.to);
        if (data[23] !== 1'b0) report_mismatch("pad bit", data[23], 0);
      end
    endtask
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [DataW-1:0] s_axis_tdata;
  logic             s_axis_tuser;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [DataW-1:0] m_axis_tdata;
  logic [1:0]       m_axis_tuser;

  delivery_board board;
  bit            no_gaps;
  int unsigned   idle_cycles;

  key_request_matcher_core #(
    .DEPTH(Depth)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    board = new();
    no_gaps = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    m_axis_tready = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // output side: random stalls unless no_gaps is set, checked at the rising edge
  initial begin
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      m_axis_tready = no_gaps || ($urandom_range(99) >= 6);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      board.check_delivery(m_axis_tdata, m_axis_tuser);
  end

  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("[key_request_matcher_core] ERROR");
        $finish;
      end
    end
  end

  task automatic send_word(logic cmd, logic [KeyW-1:0] key, logic [RidW-1:0] rid);
    if (!no_gaps && $urandom_range(99) < 6) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(3)) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tuser = cmd;
    s_axis_tdata = {1'b0, rid, key};
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_event(cmd, key, rid);
  endtask

  task automatic send_random(logic cmd);
    send_word(cmd, KeyW'($urandom), RidW'($urandom));
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    int unsigned n;
    @(posedge rst_ni);

    // directed: extremes, both orders of matching, ignored fields at all ones and all zeros
    send_word(CmdKey, 16'h0000, 7'h7f);
    send_word(CmdKey, 16'hffff, 7'h7f);
    send_word(CmdReq, 16'hffff, 7'h00);
    send_word(CmdReq, 16'h0000, 7'h7f);
    send_word(CmdReq, 16'hffff, 7'h55);
    send_word(CmdReq, 16'h0000, 7'h2a);
    send_word(CmdKey, 16'ha5a5, 7'h7f);
    send_word(CmdKey, 16'h5a5a, 7'h00);
    send_word(CmdKey, 16'h1234, 7'h7f);
    send_word(CmdReq, 16'hffff, 7'h7f);
    send_word(CmdReq, 16'h0000, 7'h00);
    send_word(CmdKey, 16'h8001, 7'h00);
    send_word(CmdReq, 16'h7ffe, 7'h40);
    send_word(CmdKey, 16'hfffe, 7'h01);

    // mixed traffic
    repeat (120) send_random(logic'($urandom_range(1)));

    // key flood past full, then drain and queue requesters; no gaps here
    no_gaps = 1'b1;
    n = board.reqs_queued() + Depth - 1 + $urandom_range(2, 6);
    repeat (n) send_random(CmdKey);
    n = board.keys_queued() + $urandom_range(4, 12);
    repeat (n) send_random(CmdReq);
    no_gaps = 1'b0;

    wait_drained();

    // requester flood past full, then keys drain it
    n = Depth - 1 - board.reqs_queued() + board.keys_queued() + $urandom_range(2, 6);
    repeat (n) send_random(CmdReq);
    n = board.reqs_queued() + $urandom_range(2, 8);
    repeat (n) send_random(CmdKey);

    // mixed traffic with bursts
    repeat (20) begin
      n = $urandom_range(1, 6);
      if ($urandom_range(1)) repeat (n) send_random(CmdKey);
      else repeat (n) send_random(CmdReq);
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (board.errors == 0 && board.pending() == 0)
      $display("[key_request_matcher_core] OK");
    else
      $display("[key_request_matcher_core] ERROR");
    $finish;
  end

endmodule
